>>> design/mse_pkg.sv
// Shared package for the MIPS subset execute core.
// Holds opcodes, function codes, status codes, result type and decode helpers.
// No dependencies.
package mse_pkg;

  localparam int unsigned MEM_WORDS_DEF = 1024;
  localparam logic [15:0] EXIT_CODE_RST = 16'h0010;

  localparam int unsigned IN_W  = 32;
  localparam int unsigned OUT_W = 112;

  localparam logic [5:0] OP_RTYPE = 6'h00;
  localparam logic [5:0] OP_J     = 6'h02;
  localparam logic [5:0] OP_JAL   = 6'h03;
  localparam logic [5:0] OP_BEQ   = 6'h04;
  localparam logic [5:0] OP_BNE   = 6'h05;
  localparam logic [5:0] OP_ADDI  = 6'h08;
  localparam logic [5:0] OP_ADDIU = 6'h09;
  localparam logic [5:0] OP_SLTI  = 6'h0a;
  localparam logic [5:0] OP_SLTIU = 6'h0b;
  localparam logic [5:0] OP_ANDI  = 6'h0c;
  localparam logic [5:0] OP_ORI   = 6'h0d;
  localparam logic [5:0] OP_XORI  = 6'h0e;
  localparam logic [5:0] OP_LUI   = 6'h0f;
  localparam logic [5:0] OP_LB    = 6'h20;
  localparam logic [5:0] OP_LH    = 6'h21;
  localparam logic [5:0] OP_LW    = 6'h23;
  localparam logic [5:0] OP_LBU   = 6'h24;
  localparam logic [5:0] OP_LHU   = 6'h25;
  localparam logic [5:0] OP_SB    = 6'h28;
  localparam logic [5:0] OP_SH    = 6'h29;
  localparam logic [5:0] OP_SW    = 6'h2b;

  localparam logic [5:0] FN_SLL     = 6'h00;
  localparam logic [5:0] FN_SRL     = 6'h02;
  localparam logic [5:0] FN_SRA     = 6'h03;
  localparam logic [5:0] FN_SLLV    = 6'h04;
  localparam logic [5:0] FN_SRLV    = 6'h06;
  localparam logic [5:0] FN_SRAV    = 6'h07;
  localparam logic [5:0] FN_JR      = 6'h08;
  localparam logic [5:0] FN_JALR    = 6'h09;
  localparam logic [5:0] FN_SYSCALL = 6'h0c;
  localparam logic [5:0] FN_ADD     = 6'h20;
  localparam logic [5:0] FN_ADDU    = 6'h21;
  localparam logic [5:0] FN_SUB     = 6'h22;
  localparam logic [5:0] FN_SUBU    = 6'h23;
  localparam logic [5:0] FN_AND     = 6'h24;
  localparam logic [5:0] FN_OR      = 6'h25;
  localparam logic [5:0] FN_XOR     = 6'h26;
  localparam logic [5:0] FN_NOR     = 6'h27;
  localparam logic [5:0] FN_SLT     = 6'h2a;
  localparam logic [5:0] FN_SLTU    = 6'h2b;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_TERM    = 2'd2;

  localparam logic [4:0] REG_V0 = 5'd2;
  localparam logic [4:0] REG_RA = 5'd31;

  typedef struct packed {
    logic [31:0] mem_address;
    logic        mem_write;
    logic [31:0] reg_value;
    logic [4:0]  reg_index;
    logic        reg_write;
    logic [31:0] next_pc;
    logic [1:0]  status;
  } result_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] npc;
    logic        wr;
    logic [4:0]  idx;
    logic [31:0] val;
    logic        ld;
    logic        st;
    logic [5:0]  op;
    logic [31:0] addr;
    logic [31:0] sdata;
  } mem_stage_t;

  function automatic logic op_known(input logic [5:0] op);
    case (op)
      OP_RTYPE, OP_J, OP_JAL, OP_BEQ, OP_BNE, OP_ADDI, OP_ADDIU, OP_SLTI,
      OP_SLTIU, OP_ANDI, OP_ORI, OP_XORI, OP_LUI, OP_LB, OP_LH, OP_LW,
      OP_LBU, OP_LHU, OP_SB, OP_SH, OP_SW: op_known = 1'b1;
      default: op_known = 1'b0;
    endcase
  endfunction

  function automatic logic fn_known(input logic [5:0] fn);
    case (fn)
      FN_SLL, FN_SRL, FN_SRA, FN_SLLV, FN_SRLV, FN_SRAV, FN_JR, FN_JALR,
      FN_SYSCALL, FN_ADD, FN_ADDU, FN_SUB, FN_SUBU, FN_AND, FN_OR, FN_XOR,
      FN_NOR, FN_SLT, FN_SLTU: fn_known = 1'b1;
      default: fn_known = 1'b0;
    endcase
  endfunction

endpackage

>>> design/mips_subset_execute_core_unit.sv
// MIPS subset execute core: takes one instruction word per transfer and returns one
// result per instruction (status, next PC, register write, store flag, byte address).
// Three stages: register read, execute with address generation and data memory read,
// then load/store merge and write-back. One instruction per cycle sustained while the output
// is not stalled; results of back-to-back dependent instructions are forwarded from the
// write-back stage and from the last retired write. After reset the data memory is cleared
// one word per cycle, and no instruction is taken until the clear has finished.
// Depends on mse_pkg, mse_regfile, mse_dmem.
module mips_subset_execute_core_unit
  import mse_pkg::*;
#(
  parameter int unsigned MEM_WORDS = MEM_WORDS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,   // instruction_word[31:0]
  output logic             m_tvalid,
  input  logic             m_tready,
  // status[1:0], next_pc[33:2], reg_write[34], reg_index[39:35], reg_value[71:40],
  // mem_write[72], mem_address[104:73], zero fill[111:105]
  output logic [OUT_W-1:0] m_tdata,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int unsigned AW   = $clog2(MEM_WORDS);
  localparam bit          POW2 = (MEM_WORDS == (1 << AW));

  logic        adv, accept, clr_busy;
  logic [15:0] exit_code;
  logic [31:0] pc;

  logic        s1_v;
  logic [31:0] s1_w;
  logic [4:0]  s1_rs;
  logic [4:0]  rs_sel;
  logic [31:0] rf_a, rf_b, a, b;

  logic          s2_v;
  mem_stage_t    s2, s2_next;
  logic [AW-1:0] s2_midx, midx_next;
  logic [31:0]   dm_rdata, cur, st_word, ld_val;

  result_t out, out_next;

  logic          wb_v;
  logic [4:0]    wb_idx;
  logic [31:0]   wb_val;
  logic          mw_v;
  logic [AW-1:0] mw_idx;
  logic [31:0]   mw_data;

  logic [31:0] ea;

  assign pready   = 1'b1;
  assign prdata   = (paddr == 3'd0) ? {16'd0, exit_code} : 32'd0;
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv && !clr_busy;
  assign accept   = s_tvalid && s_tready;
  assign m_tdata  = {7'd0, out};

  // syscall reads register 2 through the first port
  assign rs_sel = (s_tdata[31:26] == OP_RTYPE && s_tdata[5:0] == FN_SYSCALL) ?
                  REG_V0 : s_tdata[25:21];

  mse_regfile u_rf (
    .clk     (clk),
    .rst     (rst),
    .ren     (adv),
    .raddr_a (rs_sel),
    .raddr_b (s_tdata[20:16]),
    .rdata_a (rf_a),
    .rdata_b (rf_b),
    .we      (adv && s2_v && out_next.reg_write),
    .waddr   (out_next.reg_index),
    .wdata   (out_next.reg_value)
  );

  mse_dmem #(.MEM_WORDS(MEM_WORDS), .AW(AW)) u_dm (
    .clk   (clk),
    .rst   (rst),
    .ren   (adv),
    .raddr (midx_next),
    .rdata (dm_rdata),
    .we    (adv && s2_v && s2.st),
    .waddr (s2_midx),
    .wdata (st_word),
    .busy  (clr_busy)
  );

  // operand forwarding
  always_comb begin
    if (s2_v && out_next.reg_write && out_next.reg_index == s1_rs) begin
      a = out_next.reg_value;
    end else if (wb_v && wb_idx == s1_rs) begin
      a = wb_val;
    end else begin
      a = rf_a;
    end
    if (s2_v && out_next.reg_write && out_next.reg_index == s1_w[20:16]) begin
      b = out_next.reg_value;
    end else if (wb_v && wb_idx == s1_w[20:16]) begin
      b = wb_val;
    end else begin
      b = rf_b;
    end
  end

  // execute
  always_comb begin
    logic [5:0]  op, fn;
    logic [4:0]  sh;
    logic [15:0] imm;
    logic [31:0] simm, pc4;
    op   = s1_w[31:26];
    fn   = s1_w[5:0];
    sh   = s1_w[10:6];
    imm  = s1_w[15:0];
    simm = {{16{imm[15]}}, imm};
    pc4  = pc + 32'd4;
    ea   = a + simm;
    s2_next        = '0;
    s2_next.npc    = pc4;
    s2_next.op     = op;
    s2_next.sdata  = b;
    s2_next.status = ST_OK;
    if (!op_known(op) || (op == OP_RTYPE && !fn_known(fn))) begin
      s2_next.status = ST_INVALID;
      s2_next.npc    = pc;
    end else if (op == OP_RTYPE) begin
      s2_next.wr  = 1'b1;
      s2_next.idx = s1_w[15:11];
      case (fn)
        FN_SLL:  s2_next.val = b << sh;
        FN_SRL:  s2_next.val = b >> sh;
        FN_SRA:  s2_next.val = 32'($signed(b) >>> sh);
        FN_SLLV: s2_next.val = b << a[4:0];
        FN_SRLV: s2_next.val = b >> a[4:0];
        FN_SRAV: s2_next.val = 32'($signed(b) >>> a[4:0]);
        FN_JR: begin
          s2_next.wr  = 1'b0;
          s2_next.npc = a;
        end
        FN_JALR: begin
          s2_next.val = pc4;
          s2_next.npc = a;
        end
        FN_SYSCALL: begin
          s2_next.wr = 1'b0;
          if (a == {16'd0, exit_code}) begin
            s2_next.status = ST_TERM;
          end
        end
        FN_ADD, FN_ADDU: s2_next.val = a + b;
        FN_SUB, FN_SUBU: s2_next.val = a - b;
        FN_AND:  s2_next.val = a & b;
        FN_OR:   s2_next.val = a | b;
        FN_XOR:  s2_next.val = a ^ b;
        FN_NOR:  s2_next.val = ~(a | b);
        FN_SLT:  s2_next.val = {31'd0, $signed(a) < $signed(b)};
        default: s2_next.val = {31'd0, a < b};
      endcase
    end else if (op == OP_J || op == OP_JAL) begin
      s2_next.npc = {pc4[31:28], s1_w[25:0], 2'b00};
      if (op == OP_JAL) begin
        s2_next.wr  = 1'b1;
        s2_next.idx = REG_RA;
        s2_next.val = pc4;
      end
    end else begin
      s2_next.wr  = 1'b1;
      s2_next.idx = s1_w[20:16];
      case (op)
        OP_BEQ: begin
          s2_next.wr = 1'b0;
          if (a == b) s2_next.npc = pc4 + {simm[29:0], 2'b00};
        end
        OP_BNE: begin
          s2_next.wr = 1'b0;
          if (a != b) s2_next.npc = pc4 + {simm[29:0], 2'b00};
        end
        OP_ADDI, OP_ADDIU: s2_next.val = ea;
        OP_SLTI:  s2_next.val = {31'd0, $signed(a) < $signed(simm)};
        OP_SLTIU: s2_next.val = {31'd0, a < simm};
        OP_ANDI:  s2_next.val = a & {16'd0, imm};
        OP_ORI:   s2_next.val = a | {16'd0, imm};
        OP_XORI:  s2_next.val = a ^ {16'd0, imm};
        OP_LUI:   s2_next.val = {imm, 16'd0};
        OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU: begin
          s2_next.ld   = 1'b1;
          s2_next.addr = ea;
        end
        default: begin
          s2_next.wr   = 1'b0;
          s2_next.st   = 1'b1;
          s2_next.addr = ea;
        end
      endcase
    end
    if (s2_next.idx == 5'd0) begin
      s2_next.wr = 1'b0;
    end
  end

  // word index, wrapped to the memory depth
  generate
    if (POW2) begin : g_idx_mask
      assign midx_next = ea[AW+1:2];
    end else begin : g_idx_recip
      localparam int unsigned SH = 30 + AW;
      localparam logic [30:0] RECIP = 31'((64'd1 << SH) / MEM_WORDS);
      logic [29:0] x, q;
      logic [60:0] prod;
      logic [AW:0] r;
      always_comb begin
        x    = ea[31:2];
        prod = 61'(x) * 61'(RECIP);
        q    = 30'(prod >> SH);
        r    = (AW+1)'(x - 30'(q * 30'(MEM_WORDS)));
        if (r >= (AW+1)'(MEM_WORDS)) begin
          r = r - (AW+1)'(MEM_WORDS);
        end
        midx_next = r[AW-1:0];
      end
    end
  endgenerate

  // memory stage: lane select, store merge, result
  always_comb begin
    logic [1:0] lane;
    lane = s2.addr[1:0];
    cur  = (mw_v && mw_idx == s2_midx) ? mw_data : dm_rdata;
    case (s2.op)
      OP_SB: begin
        st_word = cur;
        case (lane)
          2'd0:    st_word[7:0]   = s2.sdata[7:0];
          2'd1:    st_word[15:8]  = s2.sdata[7:0];
          2'd2:    st_word[23:16] = s2.sdata[7:0];
          default: st_word[31:24] = s2.sdata[7:0];
        endcase
      end
      OP_SH: begin
        st_word = cur;
        if (lane[1]) st_word[31:16] = s2.sdata[15:0];
        else         st_word[15:0]  = s2.sdata[15:0];
      end
      default: st_word = s2.sdata;
    endcase
    case (s2.op)
      OP_LB, OP_LBU: begin
        case (lane)
          2'd0:    ld_val = {24'd0, cur[7:0]};
          2'd1:    ld_val = {24'd0, cur[15:8]};
          2'd2:    ld_val = {24'd0, cur[23:16]};
          default: ld_val = {24'd0, cur[31:24]};
        endcase
        if (s2.op == OP_LB) ld_val[31:8] = {24{ld_val[7]}};
      end
      OP_LH, OP_LHU: begin
        ld_val = {16'd0, lane[1] ? cur[31:16] : cur[15:0]};
        if (s2.op == OP_LH) ld_val[31:16] = {16{ld_val[15]}};
      end
      default: ld_val = cur;
    endcase
    out_next.status      = s2.status;
    out_next.next_pc     = s2.npc;
    out_next.reg_write   = s2.wr;
    out_next.reg_index   = s2.wr ? s2.idx : 5'd0;
    out_next.reg_value   = !s2.wr ? 32'd0 : (s2.ld ? ld_val : s2.val);
    out_next.mem_write   = s2.st;
    out_next.mem_address = s2.addr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      exit_code <= EXIT_CODE_RST;
      pc        <= '0;
      s1_v      <= 1'b0;
      s2_v      <= 1'b0;
      m_tvalid  <= 1'b0;
      wb_v      <= 1'b0;
      mw_v      <= 1'b0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == 3'd0) begin
        exit_code <= pwdata[15:0];
      end
      if (adv) begin
        s1_v     <= accept;
        s2_v     <= s1_v;
        m_tvalid <= s2_v;
        wb_v     <= s2_v && out_next.reg_write;
        mw_v     <= s2_v && s2.st;
        if (s1_v) begin
          pc <= s2_next.npc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_w    <= s_tdata;
      s1_rs   <= rs_sel;
      s2      <= s2_next;
      s2_midx <= midx_next;
      out     <= out_next;
      wb_idx  <= out_next.reg_index;
      wb_val  <= out_next.reg_value;
      mw_idx  <= s2_midx;
      mw_data <= st_word;
    end
  end

  a_no_r0_write: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out.reg_write |-> out.reg_index != 5'd0)
    else $error("register 0 reported as written");

  a_invalid_quiet: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out.status == ST_INVALID |-> !out.reg_write && !out.mem_write)
    else $error("invalid instruction changed state");

  a_pc_hold: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(pc))
    else $error("pc moved during stall");

  a_no_store_clear: assert property (@(posedge clk) disable iff (rst)
    clr_busy |-> !s1_v && !s2_v)
    else $error("instruction in flight during memory clear");

endmodule

>>> design/mse_regfile.sv
// 32 x 32 register file: one write port, two registered read ports.
// Per-entry valid bits give zero for entries not written since reset.
// Depends on mse_pkg.
module mse_regfile
  import mse_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        ren,
  input  logic [4:0]  raddr_a,
  input  logic [4:0]  raddr_b,
  output logic [31:0] rdata_a,
  output logic [31:0] rdata_b,
  input  logic        we,
  input  logic [4:0]  waddr,
  input  logic [31:0] wdata
);

  logic [31:0] mem [32];
  logic [31:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (we) begin
      vld[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ren) begin
      rdata_a <= vld[raddr_a] ? mem[raddr_a] : 32'd0;
      rdata_b <= vld[raddr_b] ? mem[raddr_b] : 32'd0;
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule

>>> design/mse_dmem.sv
// Word data memory with one registered read port and one write port.
// Runs a clearing pass over every word after reset; busy while it runs.
// Depends on mse_pkg.
module mse_dmem
  import mse_pkg::*;
#(
  parameter int unsigned MEM_WORDS = MEM_WORDS_DEF,
  parameter int unsigned AW        = $clog2(MEM_WORDS)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          ren,
  input  logic [AW-1:0] raddr,
  output logic [31:0]   rdata,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [31:0]   wdata,
  output logic          busy
);

  localparam logic [AW-1:0] LAST = AW'(MEM_WORDS - 1);

  logic [31:0]   mem [MEM_WORDS];
  logic [AW-1:0] clr_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b1;
      clr_idx <= '0;
    end else if (busy) begin
      clr_idx <= clr_idx + 1'b1;
      if (clr_idx == LAST) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ren) begin
      rdata <= mem[raddr];
    end
    if (busy) begin
      mem[clr_idx] <= 32'd0;
    end else if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule
